[rtl/core/segi_pkg.sv]
// Package: shared constants for the segment intersection core.
package segi_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

endpackage

[rtl/core/segi_if.sv]
// Interfaces: segment pair input channel and intersection result channel.
interface seg_in_if #(
  parameter int unsigned COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_start_x;
  logic signed [COORD_WIDTH-1:0] a_start_y;
  logic signed [COORD_WIDTH-1:0] a_end_x;
  logic signed [COORD_WIDTH-1:0] a_end_y;
  logic signed [COORD_WIDTH-1:0] b_start_x;
  logic signed [COORD_WIDTH-1:0] b_start_y;
  logic signed [COORD_WIDTH-1:0] b_end_x;
  logic signed [COORD_WIDTH-1:0] b_end_y;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface seg_out_if #(
  parameter int unsigned COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [COORD_WIDTH-1:0] hit_x;
  logic signed [COORD_WIDTH-1:0] hit_y;
  logic                          collinear;

  modport source (output valid, hit, hit_x, hit_y, collinear, input ready);
  modport sink (input valid, hit, hit_x, hit_y, collinear, output ready);
endinterface

[rtl/core/segi_geom.sv]
// Geometry front end: differences, cross and dot products, hit decision, numerators.
module segi_geom #(
  parameter int unsigned COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [COORD_WIDTH-1:0]  a_start_x,
  input  logic signed [COORD_WIDTH-1:0]  a_start_y,
  input  logic signed [COORD_WIDTH-1:0]  a_end_x,
  input  logic signed [COORD_WIDTH-1:0]  a_end_y,
  input  logic signed [COORD_WIDTH-1:0]  b_start_x,
  input  logic signed [COORD_WIDTH-1:0]  b_start_y,
  input  logic signed [COORD_WIDTH-1:0]  b_end_x,
  input  logic signed [COORD_WIDTH-1:0]  b_end_y,
  output logic                           g_valid,
  output logic [3*COORD_WIDTH+3:0]       g_num_x,
  output logic [3*COORD_WIDTH+3:0]       g_num_y,
  output logic [2*COORD_WIDTH+2:0]       g_den,
  output logic                           g_neg_x,
  output logic                           g_neg_y,
  output logic signed [COORD_WIDTH-1:0]  g_px,
  output logic signed [COORD_WIDTH-1:0]  g_py,
  output logic                           g_hit,
  output logic                           g_col
);
  import segi_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned W1 = W + 1;
  localparam int unsigned PW = 2 * W + 2;
  localparam int unsigned DW = 2 * W + 4;
  localparam int unsigned NW = 3 * W + 4;

  // stage A: differences
  logic                 va_r;
  logic signed [W-1:0]  pxa_r, pya_r;
  logic signed [W1-1:0] rx_r, ry_r, sx_r, sy_r, dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxa_r <= a_start_x;
      pya_r <= a_start_y;
      rx_r  <= W1'(a_end_x) - W1'(a_start_x);
      ry_r  <= W1'(a_end_y) - W1'(a_start_y);
      sx_r  <= W1'(b_end_x) - W1'(b_start_x);
      sy_r  <= W1'(b_end_y) - W1'(b_start_y);
      dx_r  <= W1'(b_start_x) - W1'(a_start_x);
      dy_r  <= W1'(b_start_y) - W1'(a_start_y);
    end
  end

  // stage B: products
  logic                 vb_r, degen_r;
  logic signed [W-1:0]  pxb_r, pyb_r;
  logic signed [W1-1:0] rxb_r, ryb_r;
  logic signed [PW-1:0] m_rs_r, m_sr_r, m_dr1_r, m_dr2_r, m_ds1_r, m_ds2_r;
  logic signed [PW-1:0] m_rr1_r, m_rr2_r, m_dt1_r, m_dt2_r, m_st1_r, m_st2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen_r <= ((rx_r == '0) && (ry_r == '0)) || ((sx_r == '0) && (sy_r == '0));
      pxb_r   <= pxa_r;
      pyb_r   <= pya_r;
      rxb_r   <= rx_r;
      ryb_r   <= ry_r;
      m_rs_r  <= rx_r * sy_r;
      m_sr_r  <= ry_r * sx_r;
      m_dr1_r <= dx_r * ry_r;
      m_dr2_r <= dy_r * rx_r;
      m_ds1_r <= dx_r * sy_r;
      m_ds2_r <= dy_r * sx_r;
      m_rr1_r <= rx_r * rx_r;
      m_rr2_r <= ry_r * ry_r;
      m_dt1_r <= dx_r * rx_r;
      m_dt2_r <= dy_r * ry_r;
      m_st1_r <= sx_r * rx_r;
      m_st2_r <= sy_r * ry_r;
    end
  end

  // stage C: cross and dot sums
  logic                 vc_r, degenc_r;
  logic signed [W-1:0]  pxc_r, pyc_r;
  logic signed [W1-1:0] rxc_r, ryc_r;
  logic signed [DW-1:0] den_r, un_r, tn_r, len_r, t0_r, t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenc_r <= degen_r;
      pxc_r    <= pxb_r;
      pyc_r    <= pyb_r;
      rxc_r    <= rxb_r;
      ryc_r    <= ryb_r;
      den_r    <= DW'(m_rs_r) - DW'(m_sr_r);
      un_r     <= DW'(m_dr1_r) - DW'(m_dr2_r);
      tn_r     <= DW'(m_ds1_r) - DW'(m_ds2_r);
      len_r    <= DW'(m_rr1_r) + DW'(m_rr2_r);
      t0_r     <= DW'(m_dt1_r) + DW'(m_dt2_r);
      t1_r     <= DW'(m_dt1_r) + DW'(m_dt2_r) + DW'(m_st1_r) + DW'(m_st2_r);
    end
  end

  // stage D: decide
  logic signed [DW-1:0] tmin, tmax, den_g, tn_g, un_g, tsel, dsel;
  logic                 hit_d, col_d;

  always_comb begin
    tmin  = (t0_r <= t1_r) ? t0_r : t1_r;
    tmax  = (t0_r <= t1_r) ? t1_r : t0_r;
    den_g = den_r[DW-1] ? -den_r : den_r;
    tn_g  = den_r[DW-1] ? -tn_r : tn_r;
    un_g  = den_r[DW-1] ? -un_r : un_r;
    hit_d = 1'b0;
    col_d = 1'b0;
    tsel  = tn_g;
    dsel  = den_g;
    if (degenc_r) begin
      hit_d = 1'b0;
    end else if (den_r == '0) begin
      dsel = len_r;
      tsel = tmin[DW-1] ? '0 : tmin;
      if ((un_r == '0) && !tmax[DW-1] && (tmin <= len_r)) begin
        hit_d = 1'b1;
        col_d = 1'b1;
      end
    end else begin
      hit_d = !tn_g[DW-1] && (tn_g <= den_g) && !un_g[DW-1] && (un_g <= den_g);
    end
  end

  logic                 vd_r, hitd_r, cold_r;
  logic signed [W-1:0]  pxd_r, pyd_r;
  logic signed [W1-1:0] rxd_r, ryd_r;
  logic [DW-2:0]        tnd_r, dend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hitd_r <= hit_d;
      cold_r <= col_d;
      pxd_r  <= pxc_r;
      pyd_r  <= pyc_r;
      rxd_r  <= rxc_r;
      ryd_r  <= ryc_r;
      tnd_r  <= tsel[DW-2:0];
      dend_r <= dsel[DW-2:0];
    end
  end

  // stage E: numerators on magnitudes
  logic [W1-1:0] arx, ary;

  assign arx = rxd_r[W1-1] ? W1'(-rxd_r) : W1'(rxd_r);
  assign ary = ryd_r[W1-1] ? W1'(-ryd_r) : W1'(ryd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_num_x <= NW'(tnd_r) * NW'(arx);
      g_num_y <= NW'(tnd_r) * NW'(ary);
      g_den   <= dend_r;
      g_neg_x <= rxd_r[W1-1];
      g_neg_y <= ryd_r[W1-1];
      g_px    <= pxd_r;
      g_py    <= pyd_r;
      g_hit   <= hitd_r;
      g_col   <= cold_r;
    end
  end

endmodule

[rtl/core/segi_div_cell.sv]
// Divider cell: one restoring quotient bit for the x and y lanes, side data passed along.
module segi_div_cell #(
  parameter int unsigned RW = 35,
  parameter int unsigned QW = 17,
  parameter int unsigned SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          c_valid,
  input  logic [RW-1:0] c_den,
  input  logic [RW-1:0] c_rem_x,
  input  logic [QW-1:0] c_lo_x,
  input  logic [QW-1:0] c_q_x,
  input  logic [RW-1:0] c_rem_y,
  input  logic [QW-1:0] c_lo_y,
  input  logic [QW-1:0] c_q_y,
  input  logic [SW-1:0] c_side,
  output logic          n_valid,
  output logic [RW-1:0] n_den,
  output logic [RW-1:0] n_rem_x,
  output logic [QW-1:0] n_lo_x,
  output logic [QW-1:0] n_q_x,
  output logic [RW-1:0] n_rem_y,
  output logic [QW-1:0] n_lo_y,
  output logic [QW-1:0] n_q_y,
  output logic [SW-1:0] n_side
);
  import segi_pkg::*;

  logic [RW:0] tx, ty;
  logic        gx, gy;

  assign tx = {c_rem_x, c_lo_x[QW-1]};
  assign ty = {c_rem_y, c_lo_y[QW-1]};
  assign gx = tx >= {1'b0, c_den};
  assign gy = ty >= {1'b0, c_den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_valid <= 1'b0;
    end else if (en) begin
      n_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_den   <= c_den;
      n_rem_x <= gx ? RW'(tx - {1'b0, c_den}) : tx[RW-1:0];
      n_rem_y <= gy ? RW'(ty - {1'b0, c_den}) : ty[RW-1:0];
      n_lo_x  <= c_lo_x << 1;
      n_lo_y  <= c_lo_y << 1;
      n_q_x   <= {c_q_x[QW-2:0], gx};
      n_q_y   <= {c_q_y[QW-2:0], gy};
      n_side  <= c_side;
    end
  end

endmodule

[rtl/core/segment_intersection_core.sv]
// Top level: segment pair intersection pipeline with a chain of divider cells.
// Usage:
//   in_seg carries one segment pair per beat (A and B endpoints, signed Q12.4).
//   out_res carries one result per accepted pair: hit, hit_x, hit_y, collinear.
//   A beat is taken when valid and ready are both high.
// Throughput: one pair per cycle while out_res is being drained.
// Path: from input beat to result beat a pair passes five geometry
//   stages, one divider cell per quotient bit (COORD_WIDTH + 1 cells), and
//   the output register.
// The pipeline advances as a whole whenever the output register is empty or
//   being taken; when the receiver stalls with a result waiting, every stage
//   holds and in_seg.ready drops until out_res.ready returns.
// Reset clears all valid bits; no result appears until a pair is accepted.
// A miss reports hit, hit_x, hit_y and collinear all zero.
module segment_intersection_core #(
  parameter int unsigned COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  seg_in_if.sink    in_seg,
  seg_out_if.source out_res
);
  import segi_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned W1 = W + 1;
  localparam int unsigned RW = 2 * W + 3;
  localparam int unsigned NW = 3 * W + 4;
  localparam int unsigned SW = 2 * W + 4;

  logic en;
  assign en = !out_res.valid || out_res.ready;
  assign in_seg.ready = en;

  logic                 g_valid, g_neg_x, g_neg_y, g_hit, g_col;
  logic [NW-1:0]        g_num_x, g_num_y;
  logic [RW-1:0]        g_den;
  logic signed [W-1:0]  g_px, g_py;

  segi_geom #(.COORD_WIDTH(W)) u_geom (
    .clk, .rst_n, .en,
    .in_valid  (in_seg.valid),
    .a_start_x (in_seg.a_start_x),
    .a_start_y (in_seg.a_start_y),
    .a_end_x   (in_seg.a_end_x),
    .a_end_y   (in_seg.a_end_y),
    .b_start_x (in_seg.b_start_x),
    .b_start_y (in_seg.b_start_y),
    .b_end_x   (in_seg.b_end_x),
    .b_end_y   (in_seg.b_end_y),
    .g_valid, .g_num_x, .g_num_y, .g_den, .g_neg_x, .g_neg_y,
    .g_px, .g_py, .g_hit, .g_col
  );

  logic          ch_valid [W1+1];
  logic [RW-1:0] ch_den   [W1+1];
  logic [RW-1:0] ch_rem_x [W1+1];
  logic [RW-1:0] ch_rem_y [W1+1];
  logic [W1-1:0] ch_lo_x  [W1+1];
  logic [W1-1:0] ch_lo_y  [W1+1];
  logic [W1-1:0] ch_q_x   [W1+1];
  logic [W1-1:0] ch_q_y   [W1+1];
  logic [SW-1:0] ch_side  [W1+1];

  // quotient fits in W1 bits, so the top part of the numerator starts as remainder
  assign ch_valid[0] = g_valid;
  assign ch_den[0]   = g_den;
  assign ch_rem_x[0] = g_num_x[NW-1:W1];
  assign ch_rem_y[0] = g_num_y[NW-1:W1];
  assign ch_lo_x[0]  = g_num_x[W1-1:0];
  assign ch_lo_y[0]  = g_num_y[W1-1:0];
  assign ch_q_x[0]   = '0;
  assign ch_q_y[0]   = '0;
  assign ch_side[0]  = {g_hit, g_col, g_neg_x, g_neg_y, g_px, g_py};

  for (genvar i = 0; i < W1; i++) begin : g_cell
    segi_div_cell #(.RW(RW), .QW(W1), .SW(SW)) u_cell (
      .clk, .rst_n, .en,
      .c_valid (ch_valid[i]),   .c_den   (ch_den[i]),
      .c_rem_x (ch_rem_x[i]),   .c_lo_x  (ch_lo_x[i]),   .c_q_x (ch_q_x[i]),
      .c_rem_y (ch_rem_y[i]),   .c_lo_y  (ch_lo_y[i]),   .c_q_y (ch_q_y[i]),
      .c_side  (ch_side[i]),
      .n_valid (ch_valid[i+1]), .n_den   (ch_den[i+1]),
      .n_rem_x (ch_rem_x[i+1]), .n_lo_x  (ch_lo_x[i+1]), .n_q_x (ch_q_x[i+1]),
      .n_rem_y (ch_rem_y[i+1]), .n_lo_y  (ch_lo_y[i+1]), .n_q_y (ch_q_y[i+1]),
      .n_side  (ch_side[i+1])
    );
  end

  logic                hit_e, col_e, neg_xe, neg_ye;
  logic signed [W-1:0] px_e, py_e;
  logic [W-1:0]        qx_e, qy_e, hx_nxt, hy_nxt;

  assign {hit_e, col_e, neg_xe, neg_ye, px_e, py_e} = ch_side[W1];
  assign qx_e   = ch_q_x[W1][W-1:0];
  assign qy_e   = ch_q_y[W1][W-1:0];
  assign hx_nxt = W'(px_e) + (neg_xe ? W'(-qx_e) : qx_e);
  assign hy_nxt = W'(py_e) + (neg_ye ? W'(-qy_e) : qy_e);

  logic                out_valid_r, out_hit_r, out_col_r;
  logic signed [W-1:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ch_valid[W1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= hit_e;
      out_col_r <= hit_e && col_e;
      out_x_r   <= hit_e ? $signed(hx_nxt) : '0;
      out_y_r   <= hit_e ? $signed(hy_nxt) : '0;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.hit       = out_hit_r;
  assign out_res.collinear = out_col_r;
  assign out_res.hit_x     = out_x_r;
  assign out_res.hit_y     = out_y_r;

endmodule

[rtl/core/segi_checker.sv]
// Checker: port-level assertions on the segment intersection core, bound to the top level.
module segi_checker #(
  parameter int unsigned COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_hit,
  input logic                   out_collinear,
  input logic [COORD_WIDTH-1:0] out_hit_x,
  input logic [COORD_WIDTH-1:0] out_hit_y
);
  import segi_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_x == '0 && out_hit_y == '0 && !out_collinear))
    else $error("miss carries nonzero point or collinear flag");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_hit) && $stable(out_hit_x)
      && $stable(out_hit_y) && $stable(out_collinear)))
    else $error("stalled result changed");

  a_idle_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready || !in_valid)
    else $error("input stalled with empty output");

endmodule

bind segment_intersection_core segi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_segi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_seg.valid),
  .in_ready      (in_seg.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .out_hit       (out_res.hit),
  .out_collinear (out_res.collinear),
  .out_hit_x     (out_res.hit_x),
  .out_hit_y     (out_res.hit_y)
);

[tb/segment_intersection_core_tb.sv]
// Testbench for segment_intersection_core: directed table and random pairs vs. a predictor.
module segment_intersection_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import segi_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int unsigned LATENCY = CW + 7;
  localparam int unsigned N_RANDOM = 700;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct packed {
    logic   hit;
    coord_t hx;
    coord_t hy;
    logic   col;
  } meet_t;

  typedef struct {
    seg_pair_t pair;
    logic      typed;
    meet_t     want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  seg_in_if  #(.COORD_WIDTH(CW)) in_seg ();
  seg_out_if #(.COORD_WIDTH(CW)) out_res ();

  segment_intersection_core #(.COORD_WIDTH(CW)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (in_seg.sink),
    .out_res(out_res.source)
  );

  always #5 clk = ~clk;

  meet_t  pending_meets[$];
  int     mismatches = 0;
  int     n_sent = 0;
  int     n_got = 0;
  int     n_hits = 0;
  int     n_col_hits = 0;
  int     idle_cycles = 0;
  logic   stim_done = 1'b0;
  logic   long_done = 1'b0;

  // Exact intersection at 128 bits; divisions truncate toward zero.
  function automatic meet_t predict_meet(seg_pair_t p);
    logic signed [127:0] px, py, rx, ry, sx, sy, dx, dy, den, tn, un;
    logic signed [127:0] t0, t1, tlo, thi, qx, qy;
    meet_t m;
    m = '0;
    px = p.ax0; py = p.ay0;
    rx = 128'(signed'(p.ax1)) - px;
    ry = 128'(signed'(p.ay1)) - py;
    sx = 128'(signed'(p.bx1)) - 128'(signed'(p.bx0));
    sy = 128'(signed'(p.by1)) - 128'(signed'(p.by0));
    dx = 128'(signed'(p.bx0)) - px;
    dy = 128'(signed'(p.by0)) - py;
    if ((rx == 0 && ry == 0) || (sx == 0 && sy == 0)) return m;
    den = rx * sy - ry * sx;
    if (den == 0) begin
      if (dx * ry - dy * rx != 0) return m;
      den = rx * rx + ry * ry;
      t0 = dx * rx + dy * ry;
      t1 = t0 + sx * rx + sy * ry;
      tlo = (t0 <= t1) ? t0 : t1;
      thi = (t0 <= t1) ? t1 : t0;
      if (thi < 0 || tlo > den) return m;
      tn = (tlo < 0) ? 128'sd0 : tlo;
      m.col = 1'b1;
    end else begin
      un = dx * ry - dy * rx;
      tn = dx * sy - dy * sx;
      if (den < 0) begin
        den = -den; tn = -tn; un = -un;
      end
      if (tn < 0 || tn > den || un < 0 || un > den) return m;
    end
    qx = (tn * rx) / den;
    qy = (tn * ry) / den;
    m.hit = 1'b1;
    m.hx = coord_t'(px + qx);
    m.hy = coord_t'(py + qy);
    return m;
  endfunction

  function automatic coord_t rand_coord(int unsigned span);
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom());
      1: return coord_t'($urandom_range(0, 1) ? 32767 : -32768);
      default: return coord_t'(int'($urandom_range(0, 2 * span)) - int'(span));
    endcase
  endfunction

  // Half the pairs are collinear, parallel, touching or have a vertical B; the rest is noise.
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int k, dxs, dys;
    p.ax0 = rand_coord(400); p.ay0 = rand_coord(400);
    p.ax1 = rand_coord(400); p.ay1 = rand_coord(400);
    p.bx0 = rand_coord(400); p.by0 = rand_coord(400);
    p.bx1 = rand_coord(400); p.by1 = rand_coord(400);
    case ($urandom_range(0, 9))
      0, 1: begin
        // B along A's line, possibly overlapping
        dxs = $urandom_range(0, 60) - 30; dys = $urandom_range(0, 60) - 30;
        k = $urandom_range(0, 40) - 20;
        p.ax0 = coord_t'($urandom_range(0, 2000) - 1000);
        p.ay0 = coord_t'($urandom_range(0, 2000) - 1000);
        p.ax1 = p.ax0 + coord_t'(dxs * 10); p.ay1 = p.ay0 + coord_t'(dys * 10);
        p.bx0 = p.ax0 + coord_t'(dxs * k); p.by0 = p.ay0 + coord_t'(dys * k);
        k = $urandom_range(0, 40) - 20;
        p.bx1 = p.ax0 + coord_t'(dxs * k); p.by1 = p.ay0 + coord_t'(dys * k);
      end
      2: begin
        // parallel offset
        p.bx0 = p.ax0 + 16'sd3; p.by0 = p.ay0 - 16'sd5;
        p.bx1 = p.ax1 + 16'sd3; p.by1 = p.ay1 - 16'sd5;
      end
      3: begin
        // shared endpoint
        p.bx0 = p.ax1; p.by0 = p.ay1;
      end
      4: p.bx1 = p.bx0;
      default: ;
    endcase
    return p;
  endfunction

  function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
    seg_pair_t p;
    p = '{coord_t'(a), coord_t'(b), coord_t'(c), coord_t'(d),
          coord_t'(e), coord_t'(f), coord_t'(g), coord_t'(h)};
    return p;
  endfunction

  function automatic meet_t mm(logic h, int x, int y, logic c);
    meet_t m;
    m = '{h, coord_t'(x), coord_t'(y), c};
    return m;
  endfunction

  table_row_t dir_rows[$];

  task automatic build_table();
    dir_rows = '{
      '{mk(0, 0, 32, 32, 0, 32, 32, 0), 1'b1, mm(1'b1, 16, 16, 1'b0)},
      '{mk(0, 0, 0, 0, 0, 32, 32, 0), 1'b1, mm(1'b0, 0, 0, 1'b0)},
      '{mk(0, 0, 32, 32, 5, 5, 5, 5), 1'b1, mm(1'b0, 0, 0, 1'b0)},
      '{mk(0, 0, 32, 0, 0, 16, 32, 16), 1'b1, mm(1'b0, 0, 0, 1'b0)},
      '{mk(0, 0, 32, 0, 48, 0, 64, 0), 1'b1, mm(1'b0, 0, 0, 1'b0)},
      '{mk(0, 0, 32, 0, 16, 0, 64, 0), 1'b1, mm(1'b1, 16, 0, 1'b1)},
      '{mk(0, 0, 32, 0, -16, 0, 8, 0), 1'b1, mm(1'b1, 0, 0, 1'b1)},
      '{mk(0, 0, 32, 0, 32, 0, 48, 0), 1'b1, mm(1'b1, 32, 0, 1'b1)},
      '{mk(0, 0, 32, 0, 32, 0, 32, 16), 1'b1, mm(1'b1, 32, 0, 1'b0)},
      '{mk(0, 0, 32, 0, 16, 1, 16, 16), 1'b1, mm(1'b0, 0, 0, 1'b0)},
      '{mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768), 1'b0, '0},
      '{mk(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768), 1'b0, '0},
      '{mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1'b1, mm(1'b1, 0, 0, 1'b0)},
      '{mk(-32768, -32768, 32767, 32767, -1, -1, 0, 0), 1'b0, '0},
      '{mk(0, 0, 7, 3, 0, 3, 7, 0), 1'b0, '0},
      '{mk(0, 0, -7, -3, 0, -3, -7, 0), 1'b0, '0},
      '{mk(-1, -1, -1, -1, -1, -1, -1, -1), 1'b1, mm(1'b0, 0, 0, 1'b0)},
      '{mk(32767, -32768, -32768, 32767, 0, 0, 1, 1), 1'b0, '0},
      '{mk(21845, -21846, -21846, 21845, 10922, 10922, -10923, -10923), 1'b0, '0},
      '{mk(0, 0, 100, 30, 100, 30, 0, 0), 1'b0, '0}
    };
  endtask

  task automatic send_pair(seg_pair_t p, logic typed, meet_t want);
    meet_t m;
    m = typed ? want : predict_meet(p);
    in_seg.valid <= 1'b1;
    {in_seg.a_start_x, in_seg.a_start_y, in_seg.a_end_x, in_seg.a_end_y,
     in_seg.b_start_x, in_seg.b_start_y, in_seg.b_end_x, in_seg.b_end_y} <= p;
    do @(posedge clk); while (!in_seg.ready);
    pending_meets.insert(pending_meets.size(), m);
    n_sent++;
  endtask

  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      in_seg.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    in_seg.valid <= 1'b0;
    in_seg.a_start_x <= '0; in_seg.a_start_y <= '0;
    in_seg.a_end_x <= '0;   in_seg.a_end_y <= '0;
    in_seg.b_start_x <= '0; in_seg.b_start_y <= '0;
    in_seg.b_end_x <= '0;   in_seg.b_end_y <= '0;
    build_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].want);
      sender_gap();
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      send_pair(rand_pair(), 1'b0, '0);
      if (i == 399 || i == N_RANDOM - 1) begin
        // drop valid and drain fully before going on
        in_seg.valid <= 1'b0;
        while (pending_meets.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end
    stim_done <= 1'b1;
  end

  // receiver: random stalls plus one long hold while the sender keeps offering
  initial begin
    out_res.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!long_done && n_sent >= 150) begin
        out_res.ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_done = 1'b1;
      end
      out_res.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if ($urandom_range(0, 1)) begin
        out_res.ready <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                            : $urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    meet_t got, want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got = '{out_res.hit, out_res.hit_x, out_res.hit_y, out_res.collinear};
      n_got++;
      if (got.hit) n_hits++;
      if (got.col) n_col_hits++;
      if (pending_meets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_meets.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d mismatch: expected hit=%b x=%0d y=%0d col=%b, ",
                      "got hit=%b x=%0d y=%0d col=%b"},
                     n_got - 1, want.hit, want.hx, want.hy, want.col,
                     got.hit, got.hx, got.hy, got.col);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_seg.valid && in_seg.ready) || (out_res.valid && out_res.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pending_meets.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d segment pairs, checked %0d results (%0d hits, %0d collinear).",
             n_sent, n_got, n_hits, n_col_hits);
    $display("Mismatches: %0d, leftover expectations: %0d", mismatches, pending_meets.size());
    if (mismatches == 0 && pending_meets.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

[segment_intersection_core.f]
rtl/core/segi_pkg.sv
rtl/core/segi_if.sv
rtl/core/segi_geom.sv
rtl/core/segi_div_cell.sv
rtl/core/segment_intersection_core.sv
rtl/core/segi_checker.sv
tb/segment_intersection_core_tb.sv
